// File: hdl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg: shared types and constants of the trapezoid setpoint ramp
// Request payloads, register indexes, phase codes, controller states and the
// micro-step sequence that the controller walks through for each request.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int REG_W       = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int FRAC_BITS   = 16;
  localparam int MUL_DIGIT   = 8;
  localparam int K_ONE_POINT_ONE = 72090;

  localparam logic [CFG_IDX_W-1:0] REG_FULL_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATH_SPEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATH_ACCEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_BRAKE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_COAST  = 3'd6;

  localparam logic [REG_W-1:0] RST_FULL_SPEED    = 31'd65536;
  localparam logic [REG_W-1:0] RST_PATH_SPEED    = 31'd65536;
  localparam logic [REG_W-1:0] RST_PATH_ACCEL    = 31'd65536;
  localparam logic [REG_W-1:0] RST_UPDATE_PERIOD = 31'd655;
  localparam logic [REG_W-1:0] RST_COMMAND_LIMIT = 31'd16711680;
  localparam logic [REG_W-1:0] RST_ARRIVE_BRAKE  = 31'd65536;
  localparam logic [REG_W-1:0] RST_ARRIVE_COAST  = 31'd65536;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  localparam logic [1:0] PHASE_ARRIVED = 2'd0;
  localparam logic [1:0] PHASE_STEADY  = 2'd1;
  localparam logic [1:0] PHASE_RAMPING = 2'd2;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] delta_distance;
    logic signed [31:0] target_distance;
    logic               brake_enable;
  } tsr_in_t;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic               arrived;
    logic [1:0]         move_phase;
  } tsr_out_t;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAIT, ST_OUT} ctrl_state_t;

  typedef enum logic [1:0] {UNIT_NONE, UNIT_MUL, UNIT_DIV} unit_t;

  typedef enum logic [4:0] {
    STP_T_DONE, STP_T_Q1, STP_CLP, STP_CMAX, STP_T_PP, STP_T_DACC, STP_T_PAUP,
    STP_T_NV2, STP_T_DDCC, STP_T_K, STP_T_KU, STP_N_SET, STP_A1, STP_A2,
    STP_M1, STP_M2, STP_S, STP_T_FIN, STP_N_FIN
  } step_t;

  typedef struct packed {
    step_t step;
    logic  load;
    logic  issue;
    logic  commit;
    logic  out_load;
  } tsr_cmd_t;

  typedef struct packed {
    logic unit_done;
  } tsr_stat_t;

  function automatic unit_t step_unit(input step_t s);
    unit_t u;
    unique case (s)
      STP_CLP, STP_T_PP, STP_T_PAUP, STP_T_NV2, STP_T_K, STP_T_KU,
      STP_M1, STP_M2:                               u = UNIT_MUL;
      STP_T_Q1, STP_CMAX, STP_T_DACC, STP_T_DDCC, STP_A1, STP_A2,
      STP_S:                                        u = UNIT_DIV;
      default:                                      u = UNIT_NONE;
    endcase
    return u;
  endfunction

  function automatic step_t next_step(input step_t s, input logic is_move);
    step_t n;
    unique case (s)
      STP_T_DONE: n = STP_T_Q1;
      STP_T_Q1:   n = STP_CLP;
      STP_N_SET:  n = STP_CLP;
      STP_CLP:    n = STP_CMAX;
      STP_CMAX:   n = is_move ? STP_A1 : STP_T_PP;
      STP_T_PP:   n = STP_T_DACC;
      STP_T_DACC: n = STP_T_PAUP;
      STP_T_PAUP: n = STP_T_NV2;
      STP_T_NV2:  n = STP_T_DDCC;
      STP_T_DDCC: n = STP_T_K;
      STP_T_K:    n = STP_T_KU;
      STP_T_KU:   n = STP_A1;
      STP_A1:     n = STP_A2;
      STP_A2:     n = STP_M1;
      STP_M1:     n = STP_M2;
      STP_M2:     n = STP_S;
      STP_S:      n = is_move ? STP_N_FIN : STP_T_FIN;
      default:    n = s;
    endcase
    return n;
  endfunction

endpackage

// File: hdl/trapezoid_setpoint_ramp.sv
// ----------------------------------------------------------------------------
// trapezoid_setpoint_ramp: trapezoidal motion setpoint ramp, signed Q16.16
// Sequencer plus datapath with one shared multiplier and one shared divider.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   in_data  (tsr_in_t)
//   out      from block out_valid / out_stall out_data (tsr_out_t)
//   cfg      to block   cfg_we                cfg_index, cfg_data
//
// One request is processed at a time. The radix-2 divider sets the pace:
// a tick runs seven divisions and a new move four, and a division ends
// early when the numerator is zero or the quotient saturates.
// Reset is synchronous; it restores the register defaults and the idle state.
// A finished result waits in the output register while the next request is
// taken; a result stalled there holds the sequencer before its next output.
// ----------------------------------------------------------------------------
module trapezoid_setpoint_ramp #(
  parameter int FIXED_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tsr_pkg::tsr_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tsr_pkg::tsr_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [tsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsr_pkg::REG_W-1:0]           cfg_data
);

  tsr_pkg::tsr_cmd_t  cmd;
  tsr_pkg::tsr_stat_t stat;

  tsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tsr_dp #(.W(FIXED_WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// File: hdl/tsr_mul.sv
// ----------------------------------------------------------------------------
// tsr_mul: multi-cycle unsigned multiplier
// Consumes one byte of the second operand per cycle, most significant first.
// ----------------------------------------------------------------------------
module tsr_mul #(
  parameter int OW = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OW-1:0]     a,
  input  logic [OW-1:0]     b,
  output logic              done,
  output logic [2*OW-1:0]   prod
);

  localparam int DG  = tsr_pkg::MUL_DIGIT;
  localparam int NS  = (OW + DG - 1) / DG;
  localparam int BPW = NS * DG;
  localparam int CW  = $clog2(NS + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [OW-1:0] a_r;
  logic [BPW-1:0] b_r;
  logic [2*OW-1:0] acc;
  logic [OW+DG-1:0] pp;

  assign pp   = a_r * b_r[BPW-1 -: DG];
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= BPW'(b);
      acc <= '0;
    end else if (busy) begin
      acc <= {acc[2*OW-DG-1:0], {DG{1'b0}}} + {{(OW-DG){1'b0}}, pp};
      b_r <= {b_r[BPW-DG-1:0], {DG{1'b0}}};
    end
  end

endmodule

// File: hdl/tsr_div.sv
// ----------------------------------------------------------------------------
// tsr_div: saturating radix-2 divider
// Returns min(num / den, 2^(W-1)-1); a zero numerator gives zero, a zero
// divisor with a non-zero numerator gives the largest magnitude.
// ----------------------------------------------------------------------------
module tsr_div #(
  parameter int W  = 32,
  parameter int NW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [32:0]   den,
  output logic          done,
  output logic [W-2:0]  quo
);

  localparam int MW = W - 1;
  localparam int CW = $clog2(MW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [32:0]   den_r;
  logic [32:0]   rem;
  logic [MW-1:0] nsh;
  logic [MW-1:0] q;
  logic [33:0]   r;
  logic [33:0]   diff;
  logic          num_zero;
  logic          over;

  assign num_zero = (num == '0);
  // The quotient cannot fit once the numerator reaches the divisor shifted up
  // by the quotient width, so such a division ends at once.
  assign over = (num >= NW'({den, {MW{1'b0}}}));
  assign r    = {rem, nsh[MW-1]};
  assign diff = r - {1'b0, den_r};
  assign quo  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num_zero || over) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CW'(MW);
        end
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= num[MW+32:MW];
      nsh   <= num[MW-1:0];
      if (num_zero) begin
        q <= '0;
      end else if (over) begin
        q <= '1;
      end
    end else if (busy) begin
      nsh <= {nsh[MW-2:0], 1'b0};
      if (!diff[33]) begin
        rem <= diff[32:0];
        q   <= {q[MW-2:0], 1'b1};
      end else begin
        rem <= r[32:0];
        q   <= {q[MW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hdl/tsr_dp.sv
// ----------------------------------------------------------------------------
// tsr_dp: datapath of the setpoint ramp
// Holds the configuration, the motion state and the intermediate values, and
// runs the shared multiplier and divider on the operands each step selects.
// ----------------------------------------------------------------------------
module tsr_dp #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  tsr_pkg::tsr_in_t    in_data,
  input  logic                cfg_we,
  input  logic [tsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsr_pkg::REG_W-1:0]     cfg_data,
  input  tsr_pkg::tsr_cmd_t   cmd,
  output tsr_pkg::tsr_stat_t  stat,
  output tsr_pkg::tsr_out_t   out_data
);

  localparam int MW = W - 1;
  localparam int OW = (W > 31) ? W : 31;
  localparam int NW = 2 * OW;
  localparam int XW = OW + 3;
  localparam int FB = tsr_pkg::FRAC_BITS;
  localparam logic signed [XW-1:0] X_HI   = {{(XW-MW){1'b0}}, {MW{1'b1}}};
  localparam logic signed [XW-1:0] X_LO   = {{(XW-MW){1'b1}}, {MW{1'b0}}};
  localparam logic signed [XW-1:0] X_32HI = {{(XW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [XW-1:0] X_32LO = {{(XW-31){1'b1}}, {31{1'b0}}};

  function automatic logic signed [XW-1:0] sx(input logic signed [W-1:0] v);
    return {{(XW-W){v[W-1]}}, v};
  endfunction

  function automatic logic signed [XW-1:0] ux(input logic [MW-1:0] v);
    return {{(XW-MW){1'b0}}, v};
  endfunction

  function automatic logic signed [XW-1:0] rx(input logic [30:0] v);
    return {{(XW-31){1'b0}}, v};
  endfunction

  function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] v);
    if (v > X_HI) return {1'b0, {MW{1'b1}}};
    if (v < X_LO) return {1'b1, {MW{1'b0}}};
    return v[W-1:0];
  endfunction

  function automatic logic [MW-1:0] mag_clip(input logic signed [W-1:0] v);
    logic signed [W-1:0] n;
    n = -v;
    if (v[W-1]) begin
      if (n[W-1]) return {MW{1'b1}};
      return n[MW-1:0];
    end
    return v[MW-1:0];
  endfunction

  function automatic logic [W:0] mag_full(input logic signed [W-1:0] v);
    logic [W:0] e;
    e = {v[W-1], v};
    return e[W] ? -e : e;
  endfunction

  function automatic logic [MW-1:0] shr_sat(input logic [NW-1:0] p);
    if (|p[NW-1:MW+FB]) return {MW{1'b1}};
    return p[MW+FB-1:FB];
  endfunction

  // Configuration
  logic [30:0] full_speed, path_speed, path_accel, update_period;
  logic [30:0] command_limit, arrive_brake, arrive_coast;

  // Motion state
  logic signed [W-1:0] command_value, distance_done, target_dist;
  logic signed [W-1:0] speed_estimate, ramp_step;
  logic [1:0]          phase_state;
  logic                braking_mode;

  // Intermediate values
  tsr_pkg::tsr_in_t in_r;
  logic [MW-1:0] cmax, dacc, ddcc, nv, tmp, rem;

  logic signed [W-1:0] dd_w, dist_w;
  logic [MW-1:0]       dd_mag;
  logic [OW-1:0]       mul_a, mul_b;
  logic [NW-1:0]       div_num, mul_prod;
  logic [32:0]         div_den;
  logic                mul_start, div_start, mul_done, div_done;
  logic [MW-1:0]       quo;

  assign dd_w   = sat_x({{(XW-32){in_r.delta_distance[31]}}, in_r.delta_distance});
  assign dist_w = sat_x({{(XW-32){in_r.target_distance[31]}}, in_r.target_distance});
  assign dd_mag = mag_clip(dd_w);

  assign mul_start = cmd.issue && (tsr_pkg::step_unit(cmd.step) == tsr_pkg::UNIT_MUL);
  assign div_start = cmd.issue && (tsr_pkg::step_unit(cmd.step) == tsr_pkg::UNIT_DIV);
  assign stat.unit_done = mul_done | div_done;

  tsr_mul #(.OW(OW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  tsr_div #(.W(W), .NW(NW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = '0;
    unique case (cmd.step)
      tsr_pkg::STP_CLP: begin
        mul_a = OW'(command_limit);
        mul_b = OW'(path_speed);
      end
      tsr_pkg::STP_T_PP: begin
        mul_a = OW'(path_speed);
        mul_b = OW'(path_speed);
      end
      tsr_pkg::STP_T_PAUP: begin
        mul_a = OW'(path_accel);
        mul_b = OW'(update_period);
      end
      tsr_pkg::STP_T_NV2: begin
        mul_a = OW'(nv);
        mul_b = OW'(nv);
      end
      tsr_pkg::STP_T_K: begin
        mul_a = OW'(tsr_pkg::K_ONE_POINT_ONE);
        mul_b = OW'(nv);
      end
      tsr_pkg::STP_T_KU, tsr_pkg::STP_M1: begin
        mul_a = OW'(tmp);
        mul_b = OW'(update_period);
      end
      tsr_pkg::STP_M2: begin
        mul_a = OW'(cmax);
        mul_b = OW'(tmp);
      end
      tsr_pkg::STP_T_Q1: begin
        div_num = NW'({dd_mag, {FB{1'b0}}});
        div_den = 33'(update_period);
      end
      tsr_pkg::STP_CMAX: begin
        div_num = mul_prod;
        div_den = 33'(full_speed);
      end
      tsr_pkg::STP_T_DACC, tsr_pkg::STP_T_DDCC: begin
        div_num = mul_prod;
        div_den = {1'b0, path_accel, 1'b0};
      end
      tsr_pkg::STP_A1: begin
        div_num = NW'({rem, {FB{1'b0}}});
        div_den = 33'(update_period);
      end
      tsr_pkg::STP_A2: begin
        div_num = NW'({tmp, {FB{1'b0}}});
        div_den = 33'(update_period);
      end
      tsr_pkg::STP_S: begin
        div_num = NW'({tmp, {FB{1'b0}}});
        div_den = 33'(path_speed);
      end
      default: begin
      end
    endcase
  end

  // Step results
  logic signed [W-1:0] speed_sum, nv_sum, ddcc_1, ddcc_2, rem_diff;
  logic [MW-1:0]       nv_c, acc_c, s_c;
  logic [OW-1:0]       ps_ow, pa_ow;

  assign ps_ow     = OW'(path_speed);
  assign pa_ow     = OW'(path_accel);
  assign speed_sum = sat_x(sx(speed_estimate) + ux(quo));
  assign nv_sum    = sat_x(sx(speed_estimate) + ux(shr_sat(mul_prod)));
  assign nv_c      = (sx(nv_sum) > rx(path_speed)) ? ps_ow[MW-1:0] : nv_sum[MW-1:0];
  assign ddcc_1    = sat_x(ux(ddcc) + ux(shr_sat(mul_prod)));
  assign ddcc_2    = sat_x(sx(ddcc_1) + rx(arrive_brake));
  assign rem_diff  = sat_x(sx(target_dist) - sx(distance_done));
  assign acc_c     = (ux(quo) > rx(path_accel)) ? pa_ow[MW-1:0] : quo;
  assign s_c       = (quo > cmax) ? cmax : quo;

  // Phase and command update at the end of a tick
  logic signed [W-1:0] s_w, ramp_new, cmd_sum, cmd_new;
  logic [W-1:0]        cmax_w;
  logic                near_start, brake_zone, overshoot, at_target, accel;
  logic [1:0]          phase_new;
  logic [30:0]         tol;

  assign s_w      = {1'b0, tmp};
  assign ramp_new = ramp_step[W-1] ? -s_w : s_w;
  assign cmax_w   = {1'b0, cmax};
  assign tol      = braking_mode ? arrive_brake : arrive_coast;
  assign near_start = (dacc >= mag_clip(distance_done)) ||
                      (sx(speed_estimate) < rx(path_speed));
  assign overshoot  = (mag_full(target_dist) < mag_full(distance_done)) &&
                      ((target_dist == '0) ||
                       (target_dist[W-1] == distance_done[W-1]));
  assign brake_zone = braking_mode && ((rem <= ddcc) || overshoot);
  assign at_target  = (ux(rem) <= rx(tol));

  always_comb begin
    phase_new = phase_state;
    accel     = 1'b1;
    cmd_new   = '0;
    if (near_start) begin
      phase_new = tsr_pkg::PHASE_RAMPING;
    end
    if (brake_zone) begin
      phase_new = tsr_pkg::PHASE_RAMPING;
      accel     = 1'b0;
    end
    if (at_target) begin
      phase_new = tsr_pkg::PHASE_ARRIVED;
    end
    cmd_sum = accel ? sat_x(sx(command_value) + sx(ramp_new))
                    : sat_x(sx(command_value) - sx(ramp_new));
    unique case (phase_new)
      tsr_pkg::PHASE_STEADY: begin
        cmd_new = command_value;
      end
      tsr_pkg::PHASE_RAMPING: begin
        cmd_new = cmd_sum;
        if (mag_full(cmd_sum) > {1'b0, cmax_w}) begin
          cmd_new   = cmd_sum[W-1] ? -cmax_w : cmax_w;
          phase_new = tsr_pkg::PHASE_STEADY;
        end
      end
      default: begin
        cmd_new = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_speed     <= tsr_pkg::RST_FULL_SPEED;
      path_speed     <= tsr_pkg::RST_PATH_SPEED;
      path_accel     <= tsr_pkg::RST_PATH_ACCEL;
      update_period  <= tsr_pkg::RST_UPDATE_PERIOD;
      command_limit  <= tsr_pkg::RST_COMMAND_LIMIT;
      arrive_brake   <= tsr_pkg::RST_ARRIVE_BRAKE;
      arrive_coast   <= tsr_pkg::RST_ARRIVE_COAST;
      command_value  <= '0;
      distance_done  <= '0;
      target_dist    <= '0;
      speed_estimate <= '0;
      ramp_step      <= '0;
      phase_state    <= tsr_pkg::PHASE_ARRIVED;
      braking_mode   <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tsr_pkg::REG_FULL_SPEED:    full_speed    <= cfg_data;
          tsr_pkg::REG_PATH_SPEED:    path_speed    <= cfg_data;
          tsr_pkg::REG_PATH_ACCEL:    path_accel    <= cfg_data;
          tsr_pkg::REG_UPDATE_PERIOD: update_period <= cfg_data;
          tsr_pkg::REG_COMMAND_LIMIT: command_limit <= cfg_data;
          tsr_pkg::REG_ARRIVE_BRAKE:  arrive_brake  <= cfg_data;
          tsr_pkg::REG_ARRIVE_COAST:  arrive_coast  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        unique case (cmd.step)
          tsr_pkg::STP_T_DONE: begin
            distance_done <= sat_x(sx(distance_done) + sx(dd_w));
          end
          tsr_pkg::STP_T_Q1: begin
            speed_estimate <= {1'b0, speed_sum[W-1:1]};
          end
          tsr_pkg::STP_N_SET: begin
            distance_done <= '0;
            target_dist   <= dist_w;
            braking_mode  <= in_r.brake_enable;
            phase_state   <= tsr_pkg::PHASE_STEADY;
          end
          tsr_pkg::STP_T_FIN: begin
            ramp_step     <= ramp_new;
            phase_state   <= phase_new;
            command_value <= cmd_new;
          end
          tsr_pkg::STP_N_FIN: begin
            if (target_dist[W-1]) begin
              ramp_step <= -s_w;
            end else if (target_dist != '0) begin
              ramp_step <= s_w;
            end else begin
              ramp_step <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.commit) begin
      unique case (cmd.step)
        tsr_pkg::STP_CMAX:   cmax <= quo;
        tsr_pkg::STP_T_DACC: dacc <= quo;
        tsr_pkg::STP_T_DDCC: ddcc <= quo;
        tsr_pkg::STP_T_PAUP: nv   <= nv_c;
        tsr_pkg::STP_T_K:    tmp  <= shr_sat(mul_prod);
        tsr_pkg::STP_T_KU: begin
          ddcc <= ddcc_2[MW-1:0];
          rem  <= mag_clip(rem_diff);
        end
        tsr_pkg::STP_N_SET:  rem  <= mag_clip(dist_w);
        tsr_pkg::STP_A1:     tmp  <= quo;
        tsr_pkg::STP_A2:     tmp  <= acc_c;
        tsr_pkg::STP_M1:     tmp  <= shr_sat(mul_prod);
        tsr_pkg::STP_M2:     tmp  <= shr_sat(mul_prod);
        tsr_pkg::STP_S:      tmp  <= s_c;
        default: begin
        end
      endcase
    end
  end

  // Result payload
  logic signed [XW-1:0] cmd_x;
  logic signed [31:0]   sp32;

  assign cmd_x = sx(command_value);

  always_comb begin
    if (cmd_x > X_32HI) begin
      sp32 = 32'sh7fffffff;
    end else if (cmd_x < X_32LO) begin
      sp32 = 32'sh80000000;
    end else begin
      sp32 = cmd_x[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.setpoint   <= sp32;
      out_data.arrived    <= (phase_state == tsr_pkg::PHASE_ARRIVED);
      out_data.move_phase <= phase_state;
    end
  end

endmodule

// File: hdl/tsr_ctrl.sv
// ----------------------------------------------------------------------------
// tsr_ctrl: sequencer of the setpoint ramp
// Walks the micro-steps of a tick or a new move, starting the shared units
// and telling the datapath when to take each result.
// ----------------------------------------------------------------------------
module tsr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic                out_stall,
  input  tsr_pkg::tsr_stat_t  stat,
  output logic                in_stall,
  output logic                out_valid,
  output tsr_pkg::tsr_cmd_t   cmd
);

  tsr_pkg::ctrl_state_t state, state_next;
  tsr_pkg::step_t       step, step_next;
  logic                 is_move, is_move_next;
  logic                 is_last;
  tsr_pkg::unit_t       unit;

  assign unit    = tsr_pkg::step_unit(step);
  assign is_last = (step == tsr_pkg::STP_T_FIN) || (step == tsr_pkg::STP_N_FIN);

  always_comb begin
    state_next   = state;
    step_next    = step;
    is_move_next = is_move;
    unique case (state)
      tsr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next   = tsr_pkg::ST_EXEC;
          is_move_next = (in_op == tsr_pkg::OP_MOVE);
          step_next    = (in_op == tsr_pkg::OP_MOVE) ? tsr_pkg::STP_N_SET
                                                     : tsr_pkg::STP_T_DONE;
        end
      end
      tsr_pkg::ST_EXEC: begin
        if (unit != tsr_pkg::UNIT_NONE) begin
          state_next = tsr_pkg::ST_WAIT;
        end else if (is_last) begin
          state_next = tsr_pkg::ST_OUT;
        end else begin
          step_next = tsr_pkg::next_step(step, is_move);
        end
      end
      tsr_pkg::ST_WAIT: begin
        if (stat.unit_done) begin
          state_next = tsr_pkg::ST_EXEC;
          step_next  = tsr_pkg::next_step(step, is_move);
        end
      end
      tsr_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = tsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.step     = step;
    cmd.load     = 1'b0;
    cmd.issue    = 1'b0;
    cmd.commit   = 1'b0;
    cmd.out_load = 1'b0;
    in_stall     = (state != tsr_pkg::ST_IDLE);
    unique case (state)
      tsr_pkg::ST_IDLE: cmd.load = in_valid;
      tsr_pkg::ST_EXEC: begin
        cmd.issue  = (unit != tsr_pkg::UNIT_NONE);
        cmd.commit = (unit == tsr_pkg::UNIT_NONE);
      end
      tsr_pkg::ST_WAIT: cmd.commit   = stat.unit_done;
      tsr_pkg::ST_OUT:  cmd.out_load = !out_valid || !out_stall;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tsr_pkg::ST_IDLE;
      step      <= tsr_pkg::STP_T_DONE;
      is_move   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      is_move <= is_move_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.unit_done |-> (state == tsr_pkg::ST_WAIT))
    else $error("unit finished while the sequencer was not waiting");

  a_issue_then_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |=> (state == tsr_pkg::ST_WAIT))
    else $error("unit started without the sequencer waiting for it");

  a_no_issue_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.issue && cmd.commit))
    else $error("step started and committed in the same cycle");

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten while still waiting");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == tsr_pkg::ST_WAIT) |-> in_stall)
    else $error("input taken while a request is in progress");

endmodule
